/* rtl/core/vzpm_pkg.sv */
package vzpm_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAME_BITS_DEF = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam int COEFF_SCALE = 1000;
	// ceil(2^38 / COEFF_SCALE): exact unsigned quotient for any 32-bit dividend
	localparam logic [28:0] COEFF_RECIP = 29'd274877907;
	localparam int COEFF_RECIP_SHIFT = 38;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_W = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_H = 1'd1;

	localparam logic [2:0] OP_SET_POS = 3'd0;
	localparam logic [2:0] OP_SET_SIZE = 3'd1;
	localparam logic [2:0] OP_MOVE = 3'd2;
	localparam logic [2:0] OP_GROW = 3'd3;
	localparam logic [2:0] OP_ZOOM = 3'd4;
	localparam logic [2:0] OP_CONVERT = 3'd5;

	typedef struct packed {
		logic [2:0] operation;
		logic signed [31:0] arg_a;
		logic signed [31:0] arg_b;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] view_x;
		logic signed [31:0] view_y;
		logic signed [31:0] view_w;
		logic signed [31:0] view_h;
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] zoom_coefficient;
		logic zoom_applied;
		logic divide_error;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture item
		logic gcd_step;  // one Euclid remainder step (uses divider)
		logic div_start; // start a division
		logic [2:0] div_sel;
		logic save;      // latch division result by div_sel
		logic apply;     // update state from item
		logic finish;    // build result
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic gcd_done;
	} dp_sts_t;

	localparam logic [2:0] DSEL_GCD = 3'd0;
	localparam logic [2:0] DSEL_XS = 3'd1;
	localparam logic [2:0] DSEL_YS = 3'd2;
	localparam logic [2:0] DSEL_COEF = 3'd3;
	localparam logic [2:0] DSEL_WX = 3'd4;
	localparam logic [2:0] DSEL_WY = 3'd5;

endpackage

/* rtl/core/viewport_zoom_and_pixel_map.sv */
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | in_data  (in_item_t)
// output  | out_valid| out_stall | out_data (out_item_t)
// A plain item runs apply, then the coefficient division (on the shared
// one-bit-per-cycle divider), then the result. A convert adds two divisions by the
// scale, both by a reciprocal multiply. A zoom on a nonzero frame adds the Euclid
// steps, each a remainder step on the divider, and the two step divisions.
// State resets to zero on arst_n.
// The result waits in an output register; a new item is taken once it leaves.
module viewport_zoom_and_pixel_map import vzpm_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_data
);
	logic [FRAME_BITS-1:0] fw_q, fh_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= '0;
			fh_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_FRAME_W) fw_q <= FRAME_BITS'(cfg_data);
			if (cfg_index == REG_FRAME_H) fh_q <= FRAME_BITS'(cfg_data);
		end
	end

	vzpm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .operation(in_data.operation),
		.frame_zero(fw_q == '0 || fh_q == '0), .sts(sts), .cmd(cmd)
	);

	vzpm_datapath #(.COORD_BITS(COORD_BITS), .FRAME_BITS(FRAME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .fw(fw_q), .fh(fh_q), .item(in_data),
		.cmd(cmd), .sts(sts), .result(out_data)
	);
endmodule

/* rtl/core/vzpm_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module vzpm_div import vzpm_pkg::*; #(
	parameter int W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CB = $clog2(W + 1);
	logic [CB-1:0] cnt_q;
	logic [W-1:0] q_q, r_q, d_q;
	logic [W:0] trial;

	assign busy = (cnt_q != '0);
	assign quotient = q_q;
	assign remainder = r_q;
	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CB'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

/* rtl/core/vzpm_datapath.sv */
module vzpm_datapath import vzpm_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [FRAME_BITS-1:0] fw,
	input  logic [FRAME_BITS-1:0] fh,
	input  in_item_t item,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output out_item_t result
);
	localparam int C = COORD_BITS;
	localparam int F = FRAME_BITS;
	localparam int DW = C;

	logic signed [C-1:0] px_q, py_q, sw_q, sh_q;
	logic [2:0] op_q;
	logic signed [C-1:0] a_q, b_q;
	logic [F-1:0] ga_q, gb_q, xs_q, ys_q;
	logic signed [C-1:0] coef_q, wx_q, wy_q;
	logic neg_x_q;
	logic [C-1:0] mag_q;
	logic applied_q;

	logic div_start, div_busy;
	logic [DW-1:0] dvd, dvs, quo, rem;

	vzpm_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(dvd), .divisor(dvs), .busy(div_busy),
		.quotient(quo), .remainder(rem)
	);

	// products and sums, all wrapped to C bits
	logic signed [C-1:0] sw1000, ax, ay, zx, zy, nw, nh;
	logic fz;
	logic zoom_ok;
	logic [C-1:0] mag;
	logic mneg;
	logic [C+28:0] rprod;
	logic [C-1:0] qv;
	assign fz = (fw == '0) || (fh == '0);
	assign sw1000 = C'(sw_q * C'(COEFF_SCALE));
	assign ax = C'(a_q * coef_q);
	assign ay = C'(b_q * coef_q);
	assign zx = C'(a_q * $signed({{(C-F){1'b0}}, xs_q}));
	assign zy = C'(a_q * $signed({{(C-F){1'b0}}, ys_q}));
	assign nw = C'(sw_q + (zx <<< 1));
	assign nh = C'(sh_q + (zy <<< 1));
	assign zoom_ok = (op_q == OP_ZOOM) && !fz && (a_q != '0) && (!a_q[C-1] ||
		(nw >= $signed({{(C-F){1'b0}}, fw}) && nh >= $signed({{(C-F){1'b0}}, fh})));

	always_comb begin
		dvd = '0;
		dvs = DW'(1);
		mneg = 1'b0;
		mag = '0;
		case (cmd.div_sel)
			DSEL_GCD: begin
				dvd = DW'(ga_q);
				dvs = DW'(gb_q);
			end
			DSEL_XS: begin
				dvd = DW'(fw);
				dvs = DW'(ga_q);
			end
			DSEL_YS: begin
				dvd = DW'(fh);
				dvs = DW'(ga_q);
			end
			DSEL_COEF: begin
				mneg = sw1000[C-1];
				mag = mneg ? C'(-sw1000) : sw1000;
				dvd = DW'(mag);
				dvs = DW'(fw);
			end
			DSEL_WX: begin
				mneg = ax[C-1];
				mag = mneg ? C'(-ax) : ax;
				dvd = DW'(mag);
				dvs = DW'(COEFF_SCALE);
			end
			DSEL_WY: begin
				mneg = ay[C-1];
				mag = mneg ? C'(-ay) : ay;
				dvd = DW'(mag);
				dvs = DW'(COEFF_SCALE);
			end
			default: ;
		endcase
	end
	// divisions by the scale go through the reciprocal multiply, not the divider
	assign div_start = cmd.gcd_step ||
		(cmd.div_start && cmd.div_sel != DSEL_WX && cmd.div_sel != DSEL_WY);
	assign sts.div_busy = div_busy;
	assign sts.gcd_done = (gb_q == '0);

	assign rprod = (C+29)'(mag_q) * (C+29)'(COEFF_RECIP);
	assign qv = (cmd.div_sel == DSEL_WX || cmd.div_sel == DSEL_WY) ?
		C'(rprod >> COEFF_RECIP_SHIFT) : quo[C-1:0];

	logic signed [C-1:0] sq;
	assign sq = neg_x_q ? C'(-$signed(qv)) : $signed(qv);

	always_ff @(posedge clk) begin
		if (cmd.div_start || cmd.gcd_step) begin
			neg_x_q <= mneg;
			mag_q <= mag;
		end
		if (cmd.load) begin
			op_q <= item.operation;
			a_q <= C'(item.arg_a);
			b_q <= C'(item.arg_b);
			ga_q <= fw;
			gb_q <= fh;
			applied_q <= 1'b0;
			xs_q <= '0;
			ys_q <= '0;
		end
		if (cmd.apply) applied_q <= zoom_ok;
		if (cmd.save) begin
			case (cmd.div_sel)
				DSEL_GCD: begin
					ga_q <= gb_q;
					gb_q <= F'(rem);
				end
				DSEL_XS: xs_q <= F'(quo);
				DSEL_YS: ys_q <= F'(quo);
				DSEL_COEF: coef_q <= (fw == '0) ? '0 : sq;
				DSEL_WX: wx_q <= C'(sq + px_q);
				DSEL_WY: wy_q <= C'(sq + py_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			sw_q <= '0;
			sh_q <= '0;
		end else if (cmd.apply) begin
			case (op_q)
				OP_SET_POS: begin
					px_q <= a_q;
					py_q <= b_q;
				end
				OP_SET_SIZE: begin
					sw_q <= a_q;
					sh_q <= b_q;
				end
				OP_MOVE: begin
					px_q <= C'(px_q + a_q);
					py_q <= C'(py_q + b_q);
				end
				OP_GROW: begin
					sw_q <= C'(sw_q + a_q);
					sh_q <= C'(sh_q + b_q);
				end
				OP_ZOOM: begin
					if (zoom_ok) begin
						px_q <= C'(px_q - zx);
						py_q <= C'(py_q - zy);
						sw_q <= nw;
						sh_q <= nh;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.view_x <= 32'(px_q);
			result.view_y <= 32'(py_q);
			result.view_w <= 32'(sw_q);
			result.view_h <= 32'(sh_q);
			result.world_x <= (op_q == OP_CONVERT) ? 32'(wx_q) : '0;
			result.world_y <= (op_q == OP_CONVERT) ? 32'(wy_q) : '0;
			result.zoom_coefficient <= 32'(coef_q);
			result.zoom_applied <= applied_q;
			result.divide_error <= (fw == '0);
		end
	end
endmodule

/* rtl/core/vzpm_ctrl.sv */
module vzpm_ctrl import vzpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic [2:0] operation,
	input  logic frame_zero,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_GCD = 4'd1;
	localparam logic [3:0] S_GWAIT = 4'd2;
	localparam logic [3:0] S_XS = 4'd3;
	localparam logic [3:0] S_YS = 4'd4;
	localparam logic [3:0] S_APPLY = 4'd5;
	localparam logic [3:0] S_COEF = 4'd6;
	localparam logic [3:0] S_WX = 4'd7;
	localparam logic [3:0] S_WY = 4'd8;
	localparam logic [3:0] S_DWAIT = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0] st_q, nxt_q;
	logic [2:0] dsel_q;
	logic [2:0] op_q;
	logic ov_q;
	logic take;

	assign in_stall = (st_q != S_IDLE) || (ov_q && out_stall);
	assign take = in_valid && !in_stall;
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.load = take;
		case (st_q)
			S_GCD: begin
				cmd.div_sel = DSEL_GCD;
				cmd.gcd_step = !sts.gcd_done;
			end
			S_GWAIT: begin
				cmd.div_sel = DSEL_GCD;
				cmd.save = !sts.div_busy;
			end
			S_XS, S_YS, S_COEF, S_WX, S_WY: begin
				cmd.div_sel = (st_q == S_XS) ? DSEL_XS : (st_q == S_YS) ? DSEL_YS :
					(st_q == S_COEF) ? DSEL_COEF : (st_q == S_WX) ? DSEL_WX : DSEL_WY;
				cmd.div_start = 1'b1;
			end
			S_DWAIT: begin
				cmd.div_sel = dsel_q;
				cmd.save = !sts.div_busy;
			end
			S_APPLY: cmd.apply = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			nxt_q <= S_IDLE;
			dsel_q <= DSEL_GCD;
			op_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			// remember which division is in flight
			if (cmd.div_start) dsel_q <= cmd.div_sel;
			case (st_q)
				S_IDLE: begin
					if (take) begin
						op_q <= operation;
						st_q <= (operation == OP_ZOOM && !frame_zero) ? S_GCD : S_APPLY;
					end
				end
				S_GCD: st_q <= sts.gcd_done ? S_XS : S_GWAIT;
				S_GWAIT: if (!sts.div_busy) st_q <= S_GCD;
				S_XS: begin
					nxt_q <= S_YS;
					st_q <= S_DWAIT;
				end
				S_YS: begin
					nxt_q <= S_APPLY;
					st_q <= S_DWAIT;
				end
				S_APPLY: st_q <= S_COEF;
				S_COEF: begin
					nxt_q <= (op_q == OP_CONVERT) ? S_WX : S_DONE;
					st_q <= S_DWAIT;
				end
				S_WX: begin
					nxt_q <= S_WY;
					st_q <= S_DWAIT;
				end
				S_WY: begin
					nxt_q <= S_DONE;
					st_q <= S_DWAIT;
				end
				S_DWAIT: if (!sts.div_busy) begin
					st_q <= nxt_q;
				end
				S_DONE: begin
					ov_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* dv/viewport_zoom_and_pixel_map_tb.sv */
`timescale 1ns / 1ps

module viewport_zoom_and_pixel_map_tb;
	import vzpm_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	viewport_zoom_and_pixel_map DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// viewport model state
	logic [15:0] fw, fh;
	logic signed [31:0] vx, vy, vw, vh;

	in_item_t pending_cmds[$];
	out_item_t expected_views[$];
	int mismatches;
	int idle_cycles;
	bit in_taken;
	bit hold_rx;
	int gap_left;
	int rx_wait;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] euclid_gcd(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic out_item_t apply_cmd(input in_item_t c);
		out_item_t r;
		logic signed [31:0] a, b, xs, ys, nw, nh, coeff, t;
		logic [15:0] g;
		a = c.arg_a;
		b = c.arg_b;
		r = '0;
		case (c.operation)
			OP_SET_POS: begin
				vx = a; vy = b;
			end
			OP_SET_SIZE: begin
				vw = a; vh = b;
			end
			OP_MOVE: begin
				vx = vx + a; vy = vy + b;
			end
			OP_GROW: begin
				vw = vw + a; vh = vh + b;
			end
			OP_ZOOM: begin
				xs = 0; ys = 0;
				if (fw != 0 && fh != 0) begin
					g = euclid_gcd(fw, fh);
					xs = 32'(fw / g);
					ys = 32'(fh / g);
				end
				if (xs != 0 && ys != 0 && a != 0) begin
					nw = vw + 32'(2) * xs * a;
					nh = vh + 32'(2) * ys * a;
					if (a > 0 || (nw >= $signed({16'd0, fw}) && nh >= $signed({16'd0, fh}))) begin
						vx = vx - xs * a;
						vy = vy - ys * a;
						vw = nw;
						vh = nh;
						r.zoom_applied = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (fw == 0) begin
			r.divide_error = 1'b1;
			coeff = 0;
		end else begin
			t = vw * 32'sd1000;
			coeff = t / $signed({16'd0, fw});
		end
		if (c.operation == OP_CONVERT) begin
			t = a * coeff;
			r.world_x = t / 32'sd1000 + vx;
			t = b * coeff;
			r.world_y = t / 32'sd1000 + vy;
		end
		r.view_x = vx; r.view_y = vy; r.view_w = vw; r.view_h = vh;
		r.zoom_coefficient = coeff;
		return r;
	endfunction

	// record each accepted input beat at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_views.push_back(apply_cmd(in_data));
			in_taken = 1'b1;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_taken)
					gap_left = $urandom_range(0, 17);
				in_taken = 1'b0;
				if (gap_left > 0 || pending_cmds.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					in_data <= pending_cmds.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", out_data);
				end else begin
					exp_item = expected_views.pop_front();
					if (exp_item !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h", exp_item, out_data);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_rx) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) rx_wait = $urandom_range(0, 17);
			if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [31:0] rand_arg();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 40)) - 20;
			3: return $signed($urandom_range(0, 4000)) - 2000;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		in_item_t c;
		c.operation = op; c.arg_a = a; c.arg_b = b;
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_frame(input logic [15:0] w, input logic [15:0] h);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_FRAME_W; cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_FRAME_H; cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		fw = w; fh = h;
	endtask

	task automatic random_phase(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 30) add_cmd(OP_ZOOM, $signed($urandom_range(0, 20)) - 10, rand_arg());
			else if (k < 55) add_cmd(OP_CONVERT, rand_arg(), rand_arg());
			else if (k < 65) add_cmd(OP_SET_SIZE, $signed($urandom_range(0, 5000)), $signed($urandom_range(0, 5000)));
			else if (k < 95) add_cmd(3'($urandom_range(0, 3)), rand_arg(), rand_arg());
			else add_cmd(3'($urandom_range(6, 7)), rand_arg(), rand_arg());
		end
	endtask

	initial begin
		int hold;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		fw = 0; fh = 0; vx = 0; vy = 0; vw = 0; vh = 0;
		mismatches = 0; idle_cycles = 0; in_taken = 0; hold_rx = 0;
		gap_left = 0; rx_wait = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero frame: divide error, zooms ignored
		add_cmd(OP_SET_SIZE, 100, 50);
		add_cmd(OP_ZOOM, 3, 0);
		add_cmd(OP_CONVERT, 10, 10);
		add_cmd(3'd6, 1, 2);
		add_cmd(3'd7, -1, -2);
		drain();
		write_frame(16'd640, 16'd0);
		add_cmd(OP_ZOOM, 2, 0);
		add_cmd(OP_CONVERT, 5, 5);
		drain();
		write_frame(16'd640, 16'd480);
		add_cmd(OP_SET_POS, 32'sh7fffffff, 32'sh80000000);
		add_cmd(OP_MOVE, 1, -1);
		add_cmd(OP_SET_SIZE, 640, 480);
		add_cmd(OP_ZOOM, 0, 0);
		add_cmd(OP_ZOOM, 2, 0);
		add_cmd(OP_ZOOM, -1, 0);
		add_cmd(OP_ZOOM, -5, 0);
		add_cmd(OP_GROW, 32'sh7fffffff, 32'sh80000000);
		add_cmd(OP_CONVERT, 32'sh7fffffff, 32'sh80000000);
		add_cmd(OP_SET_SIZE, 32'sh80000000, 32'sh7fffffff);
		add_cmd(OP_CONVERT, -1, 1);
		add_cmd(OP_ZOOM, 32'sh7fffffff, -1);
		add_cmd(OP_ZOOM, 32'sh80000000, 1);
		drain();

		write_frame(16'hffff, 16'hffff);
		random_phase(300);
		// long receiver hold while the sender keeps offering
		hold_rx = 1;
		for (hold = 0; hold < 600; hold++) @(posedge clk);
		hold_rx = 0;
		drain();
		write_frame(16'd1, 16'd1);
		random_phase(400);
		drain();
		write_frame(16'd1920, 16'd1080);
		random_phase(500);
		drain();
		write_frame(16'd7, 16'd13);
		random_phase(400);
		drain();
		write_frame(16'd0, 16'd0);
		random_phase(100);
		drain();
		write_frame(16'h5a5a, 16'ha5a5);
		random_phase(300);
		drain();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* viewport_zoom_and_pixel_map.f */
rtl/core/vzpm_pkg.sv
rtl/core/vzpm_div.sv
rtl/core/vzpm_datapath.sv
rtl/core/vzpm_ctrl.sv
rtl/core/viewport_zoom_and_pixel_map.sv
dv/viewport_zoom_and_pixel_map_tb.sv
